// File: sv/neighbor_table_with_aging_core_assert.svh
// Assertion macros for the neighbour table block.
`ifndef NEIGHBOR_TABLE_WITH_AGING_CORE_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define NTA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NTA_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NTA_ASSERT(label, clk, rst_n, prop, msg)
`define NTA_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/nta_pkg.sv
`timescale 1ns / 1ps
package nta_pkg;
	localparam int MAX_ENTRIES_DEF = 16;
	localparam logic [15:0] AGE_LIMIT_RST = 16'd64;
	localparam logic [7:0] NEAREST_RST = 8'd90;
	localparam logic REG_AGE_LIMIT = 1'b0;
	localparam logic REG_NEAREST = 1'b1;
	localparam logic MODE_STORE = 1'b0;
	localparam logic MODE_PURGE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOOKUP, ST_PURGE, ST_REPORT, ST_OUT
	} state_t;

	typedef struct packed {
		logic [0:0]  mode;
		logic [15:0] sender_id;
		logic [7:0]  distance;
		logic [7:0]  sender_count;
		logic [7:0]  sender_state;
		logic [15:0] sender_reading;
		logic [7:0]  sender_ttl;
		logic [7:0]  sender_grad;
		logic [31:0] now_ticks;
		logic [15:0] own_reading;
		logic [7:0]  own_grad;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  entry_count;
		logic [7:0]  nearest_dist;
		logic        best_valid;
		logic [3:0]  best_index;
		logic [15:0] best_reading;
		logic [7:0]  best_ttl;
		logic [7:0]  lowest_grad;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_clear;
		logic scan_step;
		logic lookup_step;
		logic write_entry;
		logic purge_step;
		logic report_start;
		logic report_step;
		logic report_done;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_purge;
		logic lookup_hit;
		logic lookup_end;
		logic purge_end;
		logic report_end;
	} sts_t;
endpackage

// File: sv/nta_if.sv
`timescale 1ns / 1ps
interface nta_in_if;
	logic valid;
	logic ready;
	nta_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nta_out_if;
	logic valid;
	logic ready;
	nta_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nta_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [15:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: sv/nta_ctrl.sv
`timescale 1ns / 1ps
module nta_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  nta_pkg::sts_t sts,
	output nta_pkg::cmd_t cmd
);
	nta_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nta_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			nta_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = nta_pkg::ST_LOOKUP;
				end
			end
			nta_pkg::ST_LOOKUP: begin
				if (sts.is_purge) begin
					state_d = nta_pkg::ST_PURGE;
				end else if (sts.lookup_hit || sts.lookup_end) begin
					cmd.write_entry = 1'b1;
					cmd.report_start = 1'b1;
					state_d = nta_pkg::ST_REPORT;
				end else begin
					cmd.lookup_step = 1'b1;
				end
			end
			nta_pkg::ST_PURGE: begin
				if (sts.purge_end) begin
					cmd.report_start = 1'b1;
					state_d = nta_pkg::ST_REPORT;
				end else begin
					cmd.purge_step = 1'b1;
				end
			end
			nta_pkg::ST_REPORT: begin
				if (sts.report_end) begin
					cmd.report_done = 1'b1;
					state_d = nta_pkg::ST_OUT;
				end else begin
					cmd.report_step = 1'b1;
				end
			end
			nta_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = nta_pkg::ST_IDLE;
				end
			end
			default: state_d = nta_pkg::ST_IDLE;
		endcase
	end

	`include "neighbor_table_with_aging_core_assert.svh"
	`NTA_ASSERT(a_in_idle, clk, arst_n, in_ready |-> state_q == nta_pkg::ST_IDLE, "ready outside idle")
	`NTA_NEVER(a_one_owner, clk, arst_n, in_ready && out_valid, "in and out both open")
	`NTA_ASSERT(a_load_next, clk, arst_n, cmd.load |=> state_q == nta_pkg::ST_LOOKUP, "load lost")
	`NTA_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
endmodule

// File: sv/nta_datapath.sv
`timescale 1ns / 1ps
module nta_datapath #(
	parameter int MAX_ENTRIES = nta_pkg::MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  nta_pkg::in_item_t in_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_wdata,
	input  nta_pkg::cmd_t cmd,
	output nta_pkg::sts_t sts,
	output nta_pkg::out_item_t out_data
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES - 1);

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] stamp;
		logic [7:0]  hop_dist;
		logic [7:0]  pcount;
		logic [7:0]  pstate;
		logic [15:0] reading;
		logic [7:0]  ttl;
		logic [7:0]  grad;
	} entry_t;

	entry_t mem_q [MAX_ENTRIES];
	nta_pkg::in_item_t item_q;
	logic [15:0] age_limit_q;
	logic [7:0] nearest_def_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [7:0] nearest_q, ming_q, best_t_q;
	logic [15:0] best_q;
	logic [IW-1:0] slot_q;
	logic found_q;
	entry_t cur, last_e;
	logic [31:0] age;
	logic [IW-1:0] ptr_ix, prev_ix, last_ix;
	nta_pkg::out_item_t res_q;

	assign ptr_ix = ptr_q[IW-1:0];
	assign prev_ix = IW'(ptr_q - CW'(1));
	assign last_ix = IW'(count_q - CW'(1));
	assign cur = mem_q[ptr_ix];
	assign last_e = mem_q[last_ix];
	assign age = item_q.now_ticks - mem_q[prev_ix].stamp;

	// Status back to the controller.
	always_comb begin
		sts.is_purge = item_q.mode == nta_pkg::MODE_PURGE;
		sts.lookup_end = ptr_q == count_q;
		sts.lookup_hit = (ptr_q != count_q) && (cur.id == item_q.sender_id);
		sts.purge_end = ptr_q == '0;
		sts.report_end = ptr_q == count_q;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= nta_pkg::AGE_LIMIT_RST;
			nearest_def_q <= nta_pkg::NEAREST_RST;
		end else if (cfg_we) begin
			if (cfg_index == nta_pkg::REG_AGE_LIMIT) begin
				age_limit_q <= cfg_wdata;
			end else begin
				nearest_def_q <= cfg_wdata[7:0];
			end
		end
	end

	// Entry count, scan pointer and running reductions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q <= (in_data.mode == nta_pkg::MODE_PURGE) ? count_q : '0;
			end
			if (cmd.lookup_step) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.write_entry && !sts.lookup_hit && count_q < FULL) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.purge_step) begin
				ptr_q <= ptr_q - CW'(1);
				if (age > 32'(age_limit_q)) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (cmd.report_start) begin
				ptr_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.report_step) begin
				ptr_q <= ptr_q + CW'(1);
				if ((cur.reading < best_q && cur.ttl != 8'd0) ||
				    (cur.reading <= best_q && cur.ttl > best_t_q)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Item payload, selection payload and result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.report_start) begin
			nearest_q <= nearest_def_q;
			best_q <= item_q.own_reading;
			best_t_q <= 8'd0;
			ming_q <= item_q.own_grad;
			slot_q <= '0;
		end
		if (cmd.report_step) begin
			if (cur.hop_dist < nearest_q) nearest_q <= cur.hop_dist;
			if (cur.grad < ming_q) ming_q <= cur.grad;
			if ((cur.reading < best_q && cur.ttl != 8'd0) ||
			    (cur.reading <= best_q && cur.ttl > best_t_q)) begin
				best_q <= cur.reading;
				best_t_q <= cur.ttl;
				slot_q <= ptr_ix;
			end
		end
		if (cmd.report_done) begin
			res_q.entry_count <= 4'(count_q);
			res_q.nearest_dist <= nearest_q;
			res_q.lowest_grad <= ming_q;
			if (found_q && best_q != item_q.own_reading) begin
				res_q.best_valid <= 1'b1;
				res_q.best_index <= 4'(slot_q);
				res_q.best_reading <= best_q;
				res_q.best_ttl <= best_t_q;
			end else begin
				res_q.best_valid <= 1'b0;
				res_q.best_index <= 4'd0;
				res_q.best_reading <= item_q.own_reading;
				res_q.best_ttl <= 8'd0;
			end
		end
	end
	assign out_data = res_q;

	// Entry store: one write a cycle.
	always_ff @(posedge clk) begin
		if (cmd.write_entry && (sts.lookup_hit || count_q < FULL)) begin
			mem_q[ptr_ix] <= '{id: item_q.sender_id, stamp: item_q.now_ticks,
				hop_dist: item_q.distance, pcount: item_q.sender_count,
				pstate: item_q.sender_state, reading: item_q.sender_reading,
				ttl: item_q.sender_ttl - 8'd1, grad: item_q.sender_grad};
		end else if (cmd.purge_step && age > 32'(age_limit_q)) begin
			mem_q[prev_ix] <= last_e;
		end
	end

	`include "neighbor_table_with_aging_core_assert.svh"
	`NTA_ASSERT(a_cnt_max, clk, arst_n, count_q <= FULL, "table overfull")
	`NTA_ASSERT(a_ptr_max, clk, arst_n, ptr_q <= count_q || cmd.purge_step == 1'b0, "pointer past end")
	`NTA_NEVER(a_write_once, clk, arst_n, cmd.write_entry && cmd.purge_step, "store and purge mixed")
endmodule

// File: sv/neighbor_table_with_aging_core.sv
`timescale 1ns / 1ps
// Neighbour table with aging.
// Channels: in_ch carries one item, a message to store (mode 0) or a purge
// request (mode 1); out_ch returns exactly one result item per input item;
// cfg_ch writes age_limit (index 0) or nearest_default (index 1); the user
// must write it only while the block is idle, which the block does not enforce.
// Operation: a store walks the table to look up the id, a purge walks it once
// from the top, then a report pass walks the valid entries. The table holds
// at most MAX_ENTRIES - 1 entries, fifteen by default, in a single entry store.
// One item is processed at a time; in_ch.ready is high only when idle.
// Reset empties the table and loads age_limit 64 and nearest_default 90.
// A stalled receiver holds the result on out_ch and no new item is taken
// until it has been taken.
module neighbor_table_with_aging_core #(
	parameter int MAX_ENTRIES = nta_pkg::MAX_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	nta_in_if.sink in_ch,
	nta_out_if.source out_ch,
	nta_cfg_if.sink cfg_ch
);
	nta_pkg::cmd_t cmd;
	nta_pkg::sts_t sts;

	assign cfg_ch.ready = 1'b1;

	nta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	nta_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_ch.data),
		.cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_wdata(cfg_ch.wdata),
		.cmd(cmd), .sts(sts), .out_data(out_ch.data)
	);
endmodule
